// File: hdl/wcld_pkg.sv
// Shared types and constants for the weighted capped length distributor.
// No dependencies; used by the top level, wcld_ctrl and wcld_datapath.
package wcld_pkg;

	localparam int LEN_W = 24;
	localparam int GAP_W = 16;
	localparam int WGT_W = 8;
	localparam int MAX_SEGMENTS_DEF = 32;

	typedef enum logic [1:0] {
		MODE_NONE,
		MODE_GROW,
		MODE_SHRINK
	} mode_t;

	typedef enum logic [3:0] {
		OP_IDLE,
		OP_LOAD,
		OP_CLAMP,
		OP_PREP,
		OP_ROUND_INIT,
		OP_SUM,
		OP_SUM_CHK,
		OP_SKIP,
		OP_MUL,
		OP_DIV_START,
		OP_APPLY,
		OP_ROUND_END,
		OP_OUT
	} op_t;

	typedef enum logic [3:0] {
		S_LOAD,
		S_CLAMP_RD,
		S_CLAMP_EX,
		S_PREP,
		S_ROUND,
		S_SUM_RD,
		S_SUM_EX,
		S_SUM_CHK,
		S_APP_RD,
		S_APP_EX,
		S_DIV_GO,
		S_DIV_WAIT,
		S_APP_WR,
		S_APP_END,
		S_OUT_RD,
		S_OUT_EX
	} state_t;

	typedef struct packed {
		op_t  op;
		logic cfg_we;
	} cmd_t;

	typedef struct packed {
		logic in_last;
		logic idx_last;
		logic round_ok;
		logic tot_zero;
		logic elig;
		logic div_done;
		logic out_free;
	} stat_t;

endpackage

// File: hdl/weighted_capped_length_distributor_top.sv
// Top level of the weighted capped length distributor.
// Depends on wcld_pkg, wcld_ctrl and wcld_datapath.
//
// Input channel (in_valid/in_stall): one beat per segment with its minimum,
// preferred and maximum length and stretch weight. The beat with last_segment
// set closes the frame, supplies available_length and starts the solve; beats
// beyond MAX_SEGMENTS are dropped. in_stall stays high while solving and
// emitting.
// Output channel (out_valid/out_stall): one beat per segment in load order
// with offset and length, last_result on the final one. A stalled beat holds
// in the output register and the sequencer waits on it.
// Configuration (cfg_valid/cfg_ready): gap_length, taken while loading.
// Sequence: load, one beat whenever in_valid is high; clamp pass; up to N+1
// sharing rounds, each a sum pass and an apply pass with a bit-serial divide
// for each participating segment; output pass before the next frame.
// Reset clears the gap, the segment count and the output valid flag.
module weighted_capped_length_distributor_top #(
	parameter int MAX_SEGMENTS = wcld_pkg::MAX_SEGMENTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [wcld_pkg::LEN_W-1:0] min_length,
	input  logic [wcld_pkg::LEN_W-1:0] preferred_length,
	input  logic [wcld_pkg::LEN_W-1:0] max_length,
	input  logic [wcld_pkg::WGT_W-1:0] stretch_weight,
	input  logic [wcld_pkg::LEN_W-1:0] available_length,
	input  logic                       last_segment,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [wcld_pkg::LEN_W-1:0] segment_offset,
	output logic [wcld_pkg::LEN_W-1:0] segment_length,
	output logic                       last_result,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [wcld_pkg::GAP_W-1:0] gap_length
);
	import wcld_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	wcld_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.cfg_valid (cfg_valid),
		.stat      (stat),
		.in_stall  (in_stall),
		.cfg_ready (cfg_ready),
		.cmd       (cmd)
	);

	wcld_datapath #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.min_length       (min_length),
		.preferred_length (preferred_length),
		.max_length       (max_length),
		.stretch_weight   (stretch_weight),
		.available_length (available_length),
		.last_segment     (last_segment),
		.gap_length       (gap_length),
		.out_stall        (out_stall),
		.out_valid        (out_valid),
		.segment_offset   (segment_offset),
		.segment_length   (segment_length),
		.last_result      (last_result)
	);

endmodule

// File: hdl/wcld_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wcld_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hdl/wcld_div.sv
// Restoring bit-serial divider, one quotient bit per cycle.
// No dependencies; used by wcld_datapath.
module wcld_div #(
	parameter int DVD_W = 54,
	parameter int DVS_W = 30,
	parameter int Q_W   = 30
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic [Q_W-1:0]   quotient,
	output logic             done
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] dvd_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic             qbit;

	assign trial    = {rem_q, dvd_q[DVD_W-1]};
	assign qbit     = trial >= {1'b0, divisor};
	assign quotient = quo_q[Q_W-1:0];
	assign done     = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(DVD_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			quo_q <= '0;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			quo_q <= {quo_q[DVD_W-2:0], qbit};
			rem_q <= qbit ? DVS_W'(trial - {1'b0, divisor}) : trial[DVS_W-1:0];
		end
	end

endmodule

// File: hdl/wcld_datapath.sv
// Datapath: segment stores, clamp, sharing arithmetic, offsets and output register.
// Depends on wcld_pkg, wcld_ram and wcld_div.
module wcld_datapath #(
	parameter int MAX_SEGMENTS = wcld_pkg::MAX_SEGMENTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  wcld_pkg::cmd_t             cmd,
	output wcld_pkg::stat_t            stat,
	input  logic [wcld_pkg::LEN_W-1:0] min_length,
	input  logic [wcld_pkg::LEN_W-1:0] preferred_length,
	input  logic [wcld_pkg::LEN_W-1:0] max_length,
	input  logic [wcld_pkg::WGT_W-1:0] stretch_weight,
	input  logic [wcld_pkg::LEN_W-1:0] available_length,
	input  logic                       last_segment,
	input  logic [wcld_pkg::GAP_W-1:0] gap_length,
	input  logic                       out_stall,
	output logic                       out_valid,
	output logic [wcld_pkg::LEN_W-1:0] segment_offset,
	output logic [wcld_pkg::LEN_W-1:0] segment_length,
	output logic                       last_result
);
	import wcld_pkg::*;

	localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
	localparam int IDX_W  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int SUM_W  = LEN_W + CNT_W;
	localparam int WSUM_W = WGT_W + CNT_W;
	localparam int RND_W  = $clog2(MAX_SEGMENTS + 2);
	localparam int PROD_W = SUM_W + LEN_W;
	localparam int PAR_W  = 2 * LEN_W + WGT_W;
	localparam int GPS_W  = GAP_W + CNT_W;

	logic [GAP_W-1:0]  gap_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  idx_q;
	logic [LEN_W-1:0]  avail_q;
	logic [SUM_W-1:0]  total_q;
	mode_t             mode_q;
	logic [SUM_W-1:0]  amount_q;
	logic [SUM_W-1:0]  remain_q;
	logic [RND_W-1:0]  round_q;
	logic [WSUM_W-1:0] tw_q;
	logic [SUM_W-1:0]  tr_q;
	logic              use_str_q;
	logic [SUM_W-1:0]  dvs_q;
	logic              capped_q;
	logic [PROD_W-1:0] prod_s1;
	logic [LEN_W-1:0]  cursor_q;
	logic              out_valid_q;
	logic [LEN_W-1:0]  offset_q;
	logic [LEN_W-1:0]  length_q;
	logic              last_q;

	logic [PAR_W-1:0]  par_rd;
	logic [LEN_W-1:0]  len_rd;
	logic [LEN_W-1:0]  r_max, r_min;
	logic [WGT_W-1:0]  r_wgt;
	logic              has_room;
	logic              par_we, len_we;
	logic [IDX_W-1:0]  waddr;
	logic [LEN_W-1:0]  len_wdata;
	logic [LEN_W-1:0]  clamp_hi, clamp_v;
	logic              gr_elig, sh_on;
	logic [LEN_W-1:0]  gr_room, sh_room, room, w_sel, applied;
	logic              elig;
	logic [SUM_W-1:0]  sel_total;
	logic [SUM_W-1:0]  share;
	logic              div_done;
	logic              over_share;
	logic [GPS_W-1:0]  gaps;
	logic [SUM_W-1:0]  content;
	logic [LEN_W+1:0]  cur_sum;
	logic [LEN_W-1:0]  cur_next;
	logic              idx_last;

	wcld_ram #(.WIDTH(PAR_W), .DEPTH(MAX_SEGMENTS)) u_par_ram (
		.clk   (clk),
		.we    (par_we),
		.waddr (waddr),
		.wdata ({max_length, min_length, stretch_weight}),
		.raddr (idx_q[IDX_W-1:0]),
		.rdata (par_rd)
	);

	wcld_ram #(.WIDTH(LEN_W), .DEPTH(MAX_SEGMENTS)) u_len_ram (
		.clk   (clk),
		.we    (len_we),
		.waddr (waddr),
		.wdata (len_wdata),
		.raddr (idx_q[IDX_W-1:0]),
		.rdata (len_rd)
	);

	wcld_div #(.DVD_W(PROD_W), .DVS_W(SUM_W), .Q_W(SUM_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.op == OP_DIV_START),
		.dividend (prod_s1),
		.divisor  (dvs_q),
		.quotient (share),
		.done     (div_done)
	);

	assign r_max = par_rd[PAR_W-1 -: LEN_W];
	assign r_min = par_rd[LEN_W+WGT_W-1 -: LEN_W];
	assign r_wgt = par_rd[WGT_W-1:0];

	assign has_room = count_q < CNT_W'(MAX_SEGMENTS);
	assign par_we   = (cmd.op == OP_LOAD) && has_room;
	assign len_we   = par_we || (cmd.op == OP_CLAMP) || (cmd.op == OP_APPLY);
	assign waddr    = (cmd.op == OP_LOAD) ? count_q[IDX_W-1:0] : idx_q[IDX_W-1:0];

	assign clamp_hi = (len_rd > r_max) ? r_max : len_rd;
	assign clamp_v  = (clamp_hi < r_min) ? r_min : clamp_hi;

	assign gr_elig = (r_wgt != '0) && (len_rd < r_max);
	assign gr_room = r_max - len_rd;
	assign sh_on   = len_rd > r_min;
	assign sh_room = len_rd - r_min;

	always_comb begin
		if (mode_q == MODE_GROW) begin
			room = gr_room;
			w_sel = LEN_W'(r_wgt);
			elig = gr_elig;
			sel_total = SUM_W'(tw_q);
		end else begin
			room = sh_room;
			w_sel = use_str_q ? LEN_W'(r_wgt) : sh_room;
			elig = sh_on && (w_sel != '0);
			sel_total = (tw_q != '0) ? SUM_W'(tw_q) : tr_q;
		end
	end

	assign over_share = share > SUM_W'(room);
	assign applied    = over_share ? room : share[LEN_W-1:0];

	always_comb begin
		unique case (cmd.op)
			OP_LOAD:  len_wdata = preferred_length;
			OP_CLAMP: len_wdata = clamp_v;
			default:  len_wdata = (mode_q == MODE_GROW) ? len_rd + applied : len_rd - applied;
		endcase
	end

	assign gaps    = GPS_W'(gap_q) * GPS_W'(n_q - CNT_W'(1));
	assign content = (SUM_W'(avail_q) > SUM_W'(gaps)) ? SUM_W'(avail_q) - SUM_W'(gaps) : '0;

	assign cur_sum  = (LEN_W+2)'(cursor_q) + (LEN_W+2)'(len_rd) + (LEN_W+2)'(gap_q);
	assign cur_next = (cur_sum[LEN_W+1:LEN_W] != 2'b00) ? '1 : cur_sum[LEN_W-1:0];

	assign idx_last = idx_q == (n_q - CNT_W'(1));

	assign stat.in_last  = last_segment;
	assign stat.idx_last = idx_last;
	assign stat.round_ok = (round_q <= RND_W'(n_q)) && (amount_q != '0);
	assign stat.tot_zero = sel_total == '0;
	assign stat.elig     = elig;
	assign stat.div_done = div_done;
	assign stat.out_free = !out_valid_q || !out_stall;

	assign out_valid      = out_valid_q;
	assign segment_offset = offset_q;
	assign segment_length = length_q;
	assign last_result    = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q       <= '0;
			count_q     <= '0;
			n_q         <= CNT_W'(1);
			idx_q       <= '0;
			avail_q     <= '0;
			total_q     <= '0;
			mode_q      <= MODE_NONE;
			amount_q    <= '0;
			remain_q    <= '0;
			round_q     <= '0;
			tw_q        <= '0;
			tr_q        <= '0;
			use_str_q   <= 1'b0;
			dvs_q       <= '0;
			capped_q    <= 1'b0;
			cursor_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cfg_we) begin
				gap_q <= gap_length;
			end
			if (cmd.op == OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (cmd.op)
				OP_LOAD: begin
					if (last_segment) begin
						n_q     <= has_room ? count_q + CNT_W'(1) : count_q;
						count_q <= '0;
						avail_q <= available_length;
						idx_q   <= '0;
						total_q <= '0;
					end else if (has_room) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				OP_CLAMP: begin
					total_q <= total_q + SUM_W'(clamp_v);
					idx_q   <= idx_q + CNT_W'(1);
				end
				OP_PREP: begin
					round_q <= '0;
					if (content > total_q) begin
						mode_q   <= MODE_GROW;
						amount_q <= content - total_q;
					end else if (content < total_q) begin
						mode_q   <= MODE_SHRINK;
						amount_q <= total_q - content;
					end else begin
						mode_q   <= MODE_NONE;
						amount_q <= '0;
					end
				end
				OP_ROUND_INIT: begin
					idx_q    <= '0;
					cursor_q <= '0;
					tw_q     <= '0;
					tr_q     <= '0;
					capped_q <= 1'b0;
					remain_q <= amount_q;
				end
				OP_SUM: begin
					if (mode_q == MODE_GROW) begin
						if (gr_elig) begin
							tw_q <= tw_q + WSUM_W'(r_wgt);
						end
					end else if (sh_on) begin
						tw_q <= tw_q + WSUM_W'(r_wgt);
						tr_q <= tr_q + SUM_W'(sh_room);
					end
					idx_q <= idx_q + CNT_W'(1);
				end
				OP_SUM_CHK: begin
					idx_q     <= '0;
					dvs_q     <= sel_total;
					use_str_q <= tw_q != '0;
					if (sel_total == '0) begin
						amount_q <= '0;
					end
				end
				OP_SKIP: begin
					idx_q <= idx_q + CNT_W'(1);
				end
				OP_APPLY: begin
					remain_q <= remain_q - SUM_W'(applied);
					capped_q <= capped_q | over_share;
					idx_q    <= idx_q + CNT_W'(1);
				end
				OP_ROUND_END: begin
					amount_q <= capped_q ? remain_q : '0;
					round_q  <= round_q + RND_W'(1);
				end
				OP_OUT: begin
					cursor_q <= cur_next;
					idx_q    <= idx_q + CNT_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_MUL) begin
			prod_s1 <= PROD_W'(amount_q) * PROD_W'(w_sel);
		end
		if (cmd.op == OP_OUT) begin
			offset_q <= cursor_q;
			length_q <= len_rd;
			last_q   <= idx_last;
		end
	end

endmodule

// File: hdl/wcld_ctrl.sv
// Controller state machine: sequences load, clamp, sharing rounds and output.
// Depends on wcld_pkg.
module wcld_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            cfg_valid,
	input  wcld_pkg::stat_t stat,
	output logic            in_stall,
	output logic            cfg_ready,
	output wcld_pkg::cmd_t  cmd
);
	import wcld_pkg::*;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt  = state_q;
		cmd.op     = OP_IDLE;
		cmd.cfg_we = 1'b0;
		in_stall   = 1'b1;
		cfg_ready  = 1'b0;
		unique case (state_q)
			S_LOAD: begin
				in_stall   = 1'b0;
				cfg_ready  = 1'b1;
				cmd.cfg_we = cfg_valid;
				if (in_valid) begin
					cmd.op = OP_LOAD;
					if (stat.in_last) begin
						state_nxt = S_CLAMP_RD;
					end
				end
			end
			S_CLAMP_RD: state_nxt = S_CLAMP_EX;
			S_CLAMP_EX: begin
				cmd.op    = OP_CLAMP;
				state_nxt = stat.idx_last ? S_PREP : S_CLAMP_RD;
			end
			S_PREP: begin
				cmd.op    = OP_PREP;
				state_nxt = S_ROUND;
			end
			S_ROUND: begin
				cmd.op    = OP_ROUND_INIT;
				state_nxt = stat.round_ok ? S_SUM_RD : S_OUT_RD;
			end
			S_SUM_RD: state_nxt = S_SUM_EX;
			S_SUM_EX: begin
				cmd.op    = OP_SUM;
				state_nxt = stat.idx_last ? S_SUM_CHK : S_SUM_RD;
			end
			S_SUM_CHK: begin
				cmd.op    = OP_SUM_CHK;
				state_nxt = stat.tot_zero ? S_ROUND : S_APP_RD;
			end
			S_APP_RD: state_nxt = S_APP_EX;
			S_APP_EX: begin
				if (stat.elig) begin
					cmd.op    = OP_MUL;
					state_nxt = S_DIV_GO;
				end else begin
					cmd.op    = OP_SKIP;
					state_nxt = stat.idx_last ? S_APP_END : S_APP_RD;
				end
			end
			S_DIV_GO: begin
				cmd.op    = OP_DIV_START;
				state_nxt = S_DIV_WAIT;
			end
			S_DIV_WAIT: begin
				if (stat.div_done) begin
					state_nxt = S_APP_WR;
				end
			end
			S_APP_WR: begin
				cmd.op    = OP_APPLY;
				state_nxt = stat.idx_last ? S_APP_END : S_APP_RD;
			end
			S_APP_END: begin
				cmd.op    = OP_ROUND_END;
				state_nxt = S_ROUND;
			end
			S_OUT_RD: state_nxt = S_OUT_EX;
			S_OUT_EX: begin
				if (stat.out_free) begin
					cmd.op    = OP_OUT;
					state_nxt = stat.idx_last ? S_LOAD : S_OUT_RD;
				end
			end
			default: state_nxt = S_LOAD;
		endcase
	end

endmodule

// File: hdl/wcld_checker.sv
// Port-level checks on the distributor, bound to the top level.
// Depends on weighted_capped_length_distributor_top.
module wcld_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        last_segment,
	input logic        out_valid,
	input logic        out_stall,
	input logic [23:0] segment_offset,
	input logic [23:0] segment_length,
	input logic        last_result,
	input logic        cfg_ready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(segment_offset)
			&& $stable(segment_length) && $stable(last_result))
		else $error("stalled output beat changed");

	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready == !in_stall)
		else $error("config ready outside load phase");

	a_solve_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_segment |=> in_stall)
		else $error("input taken during solve");

	// the next beat of the frame may be loaded on the same edge
	a_emit_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_result |=> in_stall || out_valid)
		else $error("input taken mid frame output");

endmodule

bind weighted_capped_length_distributor_top wcld_checker u_wcld_checker (.*);
